FILE: hdl/spinor_pkg.sv
// ----------------------------------------------------------------------------
// SPI NOR flash slave package
// Command codes, state register widths and the serial flash discoverable
// parameter (SFDP) image for the datapath, and the types shared with the controller.
// ----------------------------------------------------------------------------
package spinor_pkg;

    // Width of the address register and its saturation value.
    localparam int ADDR_W = 25;
    typedef logic [ADDR_W-1:0] addr_t;
    localparam addr_t ADDR_MAX = 25'h1ffffff;

    // Byte position within a transaction saturates at this value.
    localparam logic [2:0] POS_MAX = 3'd5;

    // Sector erase granularity is 4 KB.
    localparam int SECTOR_BITS = 12;

    // SFDP table size in bytes.
    localparam addr_t SFDP_BYTES = 25'd96;

    // Electronic ID returned by the release-power-down/ID command.
    localparam logic [7:0] ELEC_ID = 8'h17;

    // Command opcodes.
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_RES   = 8'hab;
    localparam logic [7:0] OP_RDSFDP = 8'h5a;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_SE    = 8'h20;

    // Fixed words of the SFDP image.
    localparam logic [31:0] SFDP_SIGNATURE = 32'h50444653;
    localparam logic [31:0] SFDP_HEADER    = 32'hff000106;
    localparam logic [31:0] SFDP_PARAM_HDR = 32'hff000000;
    localparam logic [31:0] SFDP_PARAM_PTR = 32'h00000030;
    localparam logic [31:0] SFDP_ERASE_4K  = 32'h0000200c;

    // Word indexes (byte offset divided by four) of the non-zero words.
    localparam logic [4:0] WI_SIGNATURE = 5'h00;
    localparam logic [4:0] WI_HEADER    = 5'h01;
    localparam logic [4:0] WI_PARAM_HDR = 5'h02;
    localparam logic [4:0] WI_PARAM_PTR = 5'h03;
    localparam logic [4:0] WI_DENSITY   = 5'h0d;
    localparam logic [4:0] WI_ERASE     = 5'h13;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;       // input word taken this cycle
        logic sweep_en;     // write 0xff at the sweep pointer and step it
        logic read_done;    // load the output register from memory data
        logic prog_write;   // write back the programmed byte
    } spinor_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;     // output register is empty or drained this cycle
        logic act_read;     // current input needs an array read
        logic act_prog;     // current input needs a read-modify-write
        logic act_erase;    // current input starts a sector erase
        logic array_last;   // sweep pointer is on the last byte of the array
        logic sector_last;  // sweep pointer is on the last byte of a sector
    } spinor_status_t;

    // One byte of the SFDP image; density is the array size in bits less one.
    function automatic logic [7:0] sfdp_byte(input logic [6:0] idx,
                                             input logic [31:0] density);
        logic [31:0] w;
        w = '0;
        unique case (idx[6:2])
            WI_SIGNATURE: w = SFDP_SIGNATURE;
            WI_HEADER:    w = SFDP_HEADER;
            WI_PARAM_HDR: w = SFDP_PARAM_HDR;
            WI_PARAM_PTR: w = SFDP_PARAM_PTR;
            WI_DENSITY:   w = density;
            WI_ERASE:     w = SFDP_ERASE_4K;
            default:      w = '0;
        endcase
        return w[{idx[1:0], 3'b000} +: 8];
    endfunction

endpackage

FILE: hdl/spinor_ctrl.sv
// ----------------------------------------------------------------------------
// SPI NOR flash slave controller
// Sequences the reset clearing pass, word acceptance, array reads,
// program write-back and sector erase sweeps.
// ----------------------------------------------------------------------------
module spinor_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  spinor_pkg::spinor_status_t status,
    output spinor_pkg::spinor_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_PROG  = 5'b01000,
        ST_ERASE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.sweep_en = 1'b1;
                if (status.array_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready    = status.out_free;
                cmd.accept = s_valid && status.out_free;
                if (cmd.accept) begin
                    priority if (status.act_read) begin
                        state_next = ST_READ;
                    end else if (status.act_prog) begin
                        state_next = ST_PROG;
                    end else if (status.act_erase) begin
                        state_next = ST_ERASE;
                    end
                end
            end
            ST_READ: begin
                cmd.read_done = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_PROG: begin
                cmd.prog_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_ERASE: begin
                cmd.sweep_en = 1'b1;
                if (status.array_last || status.sector_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register; reset starts the array clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/spinor_dp.sv
// ----------------------------------------------------------------------------
// SPI NOR flash slave datapath
// Holds the transaction registers, the flash array memory, the erase sweep
// pointer and the output register, and decodes each incoming word.
// ----------------------------------------------------------------------------
module spinor_dp #(
    parameter int FLASH_BYTES = 65536
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_command,
    input  logic [7:0]                 s_mosi_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_miso_byte,
    input  spinor_pkg::spinor_cmd_t     cmd,
    output spinor_pkg::spinor_status_t  status
);

    localparam int AW = $clog2(FLASH_BYTES);
    localparam spinor_pkg::addr_t FLASH_LIMIT = spinor_pkg::addr_t'(FLASH_BYTES);
    localparam logic [AW-1:0] LAST_BYTE = AW'(FLASH_BYTES - 1);
    localparam logic [31:0] DENSITY = 32'(FLASH_BYTES * 8 - 1);

    // Flash array.
    logic [7:0] mem [FLASH_BYTES];

    // Transaction state.
    logic              wel_reg, wel_next;
    logic [7:0]        opcode_reg, opcode_next;
    logic [2:0]        pos_reg, pos_next;
    spinor_pkg::addr_t addr_reg, addr_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg;
    logic [7:0]        rdata_reg;
    logic [AW-1:0]     wr_addr_reg;
    logic [7:0]        wr_byte_reg;

    // Decode results.
    spinor_pkg::addr_t addr_shift;
    spinor_pkg::addr_t addr_inc;
    spinor_pkg::addr_t erase_base;
    logic              addr_in_flash;
    logic              base_in_flash;
    logic [7:0]        byte_out;
    logic              out_now;
    logic              act_read, act_prog, act_erase;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;

    // Address helpers: shift in an address byte, saturating increment.
    assign addr_shift    = {1'b0, addr_reg[15:0], s_mosi_byte};
    assign addr_inc      = (addr_reg == spinor_pkg::ADDR_MAX) ? addr_reg
                                                              : addr_reg + 1'b1;
    assign erase_base    = {addr_shift[spinor_pkg::ADDR_W-1:spinor_pkg::SECTOR_BITS],
                            {spinor_pkg::SECTOR_BITS{1'b0}}};
    assign addr_in_flash = addr_reg < FLASH_LIMIT;
    assign base_in_flash = erase_base < FLASH_LIMIT;

    // Decode of the word on the input channel.
    always_comb begin
        byte_out  = 8'hff;
        out_now   = 1'b0;
        act_read  = 1'b0;
        act_prog  = 1'b0;
        act_erase = 1'b0;
        wel_next    = wel_reg;
        opcode_next = opcode_reg;
        pos_next    = pos_reg;
        addr_next   = addr_reg;
        if (s_command) begin
            // Chip select release ends the transaction.
            if (opcode_reg == spinor_pkg::OP_PP || opcode_reg == spinor_pkg::OP_SE) begin
                wel_next = 1'b0;
            end
            opcode_next = '0;
            pos_next    = '0;
            addr_next   = '0;
        end else begin
            out_now  = 1'b1;
            pos_next = (pos_reg < spinor_pkg::POS_MAX) ? pos_reg + 3'd1 : pos_reg;
            if (pos_reg == 3'd0) begin
                opcode_next = s_mosi_byte;
                addr_next   = '0;
                if (s_mosi_byte == spinor_pkg::OP_WREN) begin
                    wel_next = 1'b1;
                end
            end else begin
                unique case (opcode_reg)
                    spinor_pkg::OP_RDSR: begin
                        byte_out = {6'b0, wel_reg, 1'b0};
                    end
                    spinor_pkg::OP_RES: begin
                        byte_out = (pos_reg >= 3'd4) ? spinor_pkg::ELEC_ID : 8'h00;
                    end
                    spinor_pkg::OP_RDSFDP: begin
                        byte_out = 8'h00;
                        if (pos_reg <= 3'd3) begin
                            addr_next = addr_shift;
                        end else if (pos_reg != 3'd4) begin
                            if (addr_reg < spinor_pkg::SFDP_BYTES) begin
                                byte_out = spinor_pkg::sfdp_byte(addr_reg[6:0], DENSITY);
                            end
                            addr_next = addr_inc;
                        end
                    end
                    spinor_pkg::OP_READ: begin
                        if (pos_reg <= 3'd3) begin
                            addr_next = addr_shift;
                        end else begin
                            act_read  = addr_in_flash;
                            out_now   = !addr_in_flash;
                            addr_next = addr_inc;
                        end
                    end
                    spinor_pkg::OP_PP: begin
                        if (pos_reg <= 3'd3) begin
                            addr_next = addr_shift;
                        end else begin
                            act_prog  = wel_reg && addr_in_flash;
                            addr_next = addr_inc;
                        end
                    end
                    spinor_pkg::OP_SE: begin
                        if (pos_reg <= 3'd3) begin
                            addr_next = addr_shift;
                            act_erase = (pos_reg == 3'd3) && wel_reg && base_in_flash;
                        end
                    end
                    default: begin
                        byte_out = 8'hff;
                    end
                endcase
            end
        end
    end

    // Status back to the controller.
    always_comb begin
        status.out_free    = !m_valid_reg || m_ready;
        status.act_read    = act_read;
        status.act_prog    = act_prog;
        status.act_erase   = act_erase;
        status.array_last  = (ptr_reg == LAST_BYTE);
        status.sector_last = &ptr_reg[spinor_pkg::SECTOR_BITS-1:0];
    end

    // Output register valid and sweep pointer.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if ((cmd.accept && out_now) || cmd.read_done) begin
            m_valid_next = 1'b1;
        end
        ptr_next = ptr_reg;
        if (cmd.accept && act_erase) begin
            ptr_next = erase_base[AW-1:0];
        end else if (cmd.sweep_en) begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wel_reg     <= 1'b0;
            opcode_reg  <= '0;
            pos_reg     <= '0;
            addr_reg    <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                wel_reg    <= wel_next;
                opcode_reg <= opcode_next;
                pos_reg    <= pos_next;
                addr_reg   <= addr_next;
            end
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept && out_now) begin
            m_data_reg <= byte_out;
        end else if (cmd.read_done) begin
            m_data_reg <= rdata_reg;
        end
        if (cmd.accept) begin
            wr_addr_reg <= addr_reg[AW-1:0];
            wr_byte_reg <= s_mosi_byte;
        end
    end

    // Memory write port: erase or clearing sweep, or program write-back.
    always_comb begin
        mem_we    = cmd.sweep_en || cmd.prog_write;
        mem_waddr = cmd.sweep_en ? ptr_reg : wr_addr_reg;
        mem_wdata = cmd.sweep_en ? 8'hff : (rdata_reg & wr_byte_reg);
    end

    // Flash array with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept && (act_read || act_prog)) begin
            rdata_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_miso_byte = m_data_reg;

endmodule

FILE: hdl/spi_nor_flash_slave.sv
// The slave takes one word per SPI byte clocked while selected (s_command
// low) and answers each with one MISO word; a chip-select release (s_command
// high) ends the transaction and answers nothing. After reset the block
// clears the flash array to 0xff, one byte a cycle, and accepts no word until
// that pass is done. A data read within the array, or a page program byte
// within the array with the write enable latch set, first reads the array
// into a register, then loads the output register from it or writes the
// programmed byte back through the array's one write port; a sector erase
// clears up to 4096 bytes of the sector through that port. The result waits
// in an output register, and the next word is taken while it is still
// unclaimed only if it is claimed in that same cycle.
// ----------------------------------------------------------------------------
// SPI NOR flash slave
// Top level joining the command controller and the flash datapath.
// ----------------------------------------------------------------------------
module spi_nor_flash_slave #(
    parameter int FLASH_BYTES = 65536
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_mosi_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_miso_byte
);

    spinor_pkg::spinor_cmd_t    cmd;
    spinor_pkg::spinor_status_t status;

    // Command sequencer.
    spinor_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Registers, flash array and output word.
    spinor_dp #(
        .FLASH_BYTES (FLASH_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_command   (s_command),
        .s_mosi_byte (s_mosi_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_miso_byte (m_miso_byte),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR flash slave testbench
// Drives byte and chip-select release words into the slave and checks every
// MISO word against the value in the table or a behavioural model of the
// flash kept in the bench. A short table of directed transactions comes
// first, then random transactions, mostly well formed, with random gaps on
// both channels.
module tb;

    localparam int FLASH_BYTES  = 65536;
    localparam int SECTOR_BYTES = 1 << spinor_pkg::SECTOR_BITS;
    localparam int RANDOM_WORDS = 650;

    // Word kinds on the input channel.
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Whether a table row carries its MISO value or leaves it to the model.
    localparam logic TYPED = 1'b1;
    localparam logic MODEL = 1'b0;

    typedef struct packed {
        logic       cmd;
        logic [7:0] mosi;
        logic       typed;
        logic [7:0] miso;
    } word_row_t;

    localparam int N_DIRECTED = 42;
    localparam word_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // Release with no bytes: opcode is zero, so the latch is untouched.
        '{CMD_RELEASE, 8'h00, MODEL, 8'h00},
        // Write enable, then the status shows the latch in bit 1.
        '{CMD_BYTE, spinor_pkg::OP_WREN, TYPED, 8'hff},
        '{CMD_RELEASE, 8'hff, MODEL, 8'h00},
        '{CMD_BYTE, spinor_pkg::OP_RDSR, TYPED, 8'hff},
        '{CMD_BYTE, 8'hff, TYPED, 8'h02},
        '{CMD_RELEASE, 8'h00, MODEL, 8'h00},
        // Program the last array byte, then one byte beyond the array.
        '{CMD_BYTE, spinor_pkg::OP_PP, TYPED, 8'hff},
        '{CMD_BYTE, 8'h00, TYPED, 8'hff},
        '{CMD_BYTE, 8'hff, TYPED, 8'hff},
        '{CMD_BYTE, 8'hff, TYPED, 8'hff},
        '{CMD_BYTE, 8'h00, TYPED, 8'hff},
        '{CMD_BYTE, 8'hff, TYPED, 8'hff},
        '{CMD_RELEASE, 8'h00, MODEL, 8'h00},
        // Read it back; the next address is beyond the array.
        '{CMD_BYTE, spinor_pkg::OP_READ, TYPED, 8'hff},
        '{CMD_BYTE, 8'h00, TYPED, 8'hff},
        '{CMD_BYTE, 8'hff, TYPED, 8'hff},
        '{CMD_BYTE, 8'hff, TYPED, 8'hff},
        '{CMD_BYTE, 8'h5a, TYPED, 8'h00},
        '{CMD_BYTE, 8'ha5, TYPED, 8'hff},
        '{CMD_RELEASE, 8'hff, MODEL, 8'h00},
        // Sector erase with the latch already cleared by the program.
        '{CMD_BYTE, spinor_pkg::OP_SE, TYPED, 8'hff},
        '{CMD_BYTE, 8'h00, TYPED, 8'hff},
        '{CMD_BYTE, 8'hff, TYPED, 8'hff},
        '{CMD_BYTE, 8'h00, TYPED, 8'hff},
        '{CMD_RELEASE, 8'h00, MODEL, 8'h00},
        // Discovery table read from offset zero, past the dummy byte.
        '{CMD_BYTE, spinor_pkg::OP_RDSFDP, TYPED, 8'hff},
        '{CMD_BYTE, 8'h00, TYPED, 8'h00},
        '{CMD_BYTE, 8'h00, TYPED, 8'h00},
        '{CMD_BYTE, 8'h00, TYPED, 8'h00},
        '{CMD_BYTE, 8'hff, TYPED, 8'h00},
        '{CMD_BYTE, 8'h00, TYPED, 8'h53},
        '{CMD_BYTE, 8'hff, TYPED, 8'h46},
        '{CMD_RELEASE, 8'hff, MODEL, 8'h00},
        // Electronic ID appears from the fourth byte after the opcode.
        '{CMD_BYTE, spinor_pkg::OP_RES, TYPED, 8'hff},
        '{CMD_BYTE, 8'h00, TYPED, 8'h00},
        '{CMD_BYTE, 8'hff, TYPED, 8'h00},
        '{CMD_BYTE, 8'h00, TYPED, 8'h00},
        '{CMD_BYTE, 8'hff, TYPED, spinor_pkg::ELEC_ID},
        '{CMD_RELEASE, 8'h00, MODEL, 8'h00},
        // Unknown opcode: every byte answers 0xff.
        '{CMD_BYTE, 8'hff, TYPED, 8'hff},
        '{CMD_BYTE, 8'h00, TYPED, 8'hff},
        '{CMD_RELEASE, 8'hff, MODEL, 8'h00}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_command = 1'b0;
    logic [7:0] s_mosi_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_miso_byte;

    word_row_t  stim_q [$];
    logic [7:0] miso_expected_q [$];
    int         words_sent = 0;
    int         words_taken = 0;
    int         fail_count = 0;

    // Model state of the flash.
    logic [7:0]        flash_image [FLASH_BYTES];
    logic [7:0]        sfdp_image [96];
    logic              wel;
    logic [7:0]        cur_opcode;
    logic [2:0]        byte_pos;
    spinor_pkg::addr_t data_addr;

    spi_nor_flash_slave #(
        .FLASH_BYTES (FLASH_BYTES)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_mosi_byte (s_mosi_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_miso_byte (m_miso_byte)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Little-endian word into the discovery table image.
    task automatic put_sfdp_word(input logic [4:0] word_idx, input logic [31:0] w);
        for (int k = 0; k < 4; k++) begin
            sfdp_image[int'(word_idx) * 4 + k] = w[8*k +: 8];
        end
    endtask

    // Advances the flash model by one word; returns 1 with the MISO byte
    // when the word is a clocked byte.
    function automatic bit miso_for_word(input logic cmd, input logic [7:0] mosi,
                                         output logic [7:0] miso);
        logic [2:0] pos;
        int         base;
        miso = 8'hff;
        if (cmd == CMD_RELEASE) begin
            if (cur_opcode == spinor_pkg::OP_PP || cur_opcode == spinor_pkg::OP_SE) begin
                wel = 1'b0;
            end
            cur_opcode = 8'h00;
            byte_pos = '0;
            data_addr = '0;
            return 1'b0;
        end
        pos = byte_pos;
        if (byte_pos < spinor_pkg::POS_MAX) begin
            byte_pos = byte_pos + 3'd1;
        end
        if (pos == 3'd0) begin
            cur_opcode = mosi;
            data_addr = '0;
            if (mosi == spinor_pkg::OP_WREN) begin
                wel = 1'b1;
            end
            return 1'b1;
        end
        // Bytes one to three of an addressed command shift in the address.
        case (cur_opcode)
            spinor_pkg::OP_RDSR: begin
                miso = {6'b0, wel, 1'b0};
            end
            spinor_pkg::OP_RES: begin
                miso = (pos >= 3'd4) ? spinor_pkg::ELEC_ID : 8'h00;
            end
            spinor_pkg::OP_RDSFDP: begin
                miso = 8'h00;
                if (pos <= 3'd3) begin
                    data_addr = spinor_pkg::addr_t'({data_addr[15:0], mosi});
                end else if (pos > 3'd4) begin
                    if (data_addr < spinor_pkg::SFDP_BYTES) begin
                        miso = sfdp_image[int'(data_addr)];
                    end
                    if (data_addr < spinor_pkg::ADDR_MAX) data_addr = data_addr + 1'b1;
                end
            end
            spinor_pkg::OP_READ: begin
                if (pos <= 3'd3) begin
                    data_addr = spinor_pkg::addr_t'({data_addr[15:0], mosi});
                end else begin
                    if (data_addr < spinor_pkg::addr_t'(FLASH_BYTES)) begin
                        miso = flash_image[int'(data_addr)];
                    end
                    if (data_addr < spinor_pkg::ADDR_MAX) data_addr = data_addr + 1'b1;
                end
            end
            spinor_pkg::OP_PP: begin
                if (pos <= 3'd3) begin
                    data_addr = spinor_pkg::addr_t'({data_addr[15:0], mosi});
                end else begin
                    if (wel && data_addr < spinor_pkg::addr_t'(FLASH_BYTES)) begin
                        flash_image[int'(data_addr)] &= mosi;
                    end
                    if (data_addr < spinor_pkg::ADDR_MAX) data_addr = data_addr + 1'b1;
                end
            end
            spinor_pkg::OP_SE: begin
                if (pos <= 3'd3) begin
                    data_addr = spinor_pkg::addr_t'({data_addr[15:0], mosi});
                    if (pos == 3'd3 && wel) begin
                        base = int'(data_addr) & ~(SECTOR_BYTES - 1);
                        for (int i = 0; i < SECTOR_BYTES; i++) begin
                            if (base + i < FLASH_BYTES) flash_image[base + i] = 8'hff;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return 1'b1;
    endfunction

    task automatic push_word(input logic cmd, input logic [7:0] mosi);
        stim_q.push_back('{cmd, mosi, MODEL, 8'h00});
    endtask

    task automatic push_address(input logic [23:0] a);
        push_word(CMD_BYTE, a[23:16]);
        push_word(CMD_BYTE, a[15:8]);
        push_word(CMD_BYTE, a[7:0]);
    endtask

    task automatic push_random_bytes(input int n);
        for (int k = 0; k < n; k++) begin
            push_word(CMD_BYTE, 8'($urandom));
        end
    endtask

    task automatic push_write_enable();
        push_word(CMD_BYTE, spinor_pkg::OP_WREN);
        push_word(CMD_RELEASE, 8'($urandom));
    endtask

    // Mostly a few hot sectors, so that reads meet earlier programs and
    // erases; the rest spread over the array, its top end and beyond it.
    function automatic logic [23:0] pick_flash_address();
        int roll;
        int a;
        roll = $urandom_range(99);
        if (roll < 65) begin
            case ($urandom_range(2))
                0:       a = 0;
                1:       a = SECTOR_BYTES;
                default: a = FLASH_BYTES - SECTOR_BYTES;
            endcase
            if ($urandom_range(1) == 1) begin
                a = a + $urandom_range(63);
            end else begin
                a = a + SECTOR_BYTES - 64 + $urandom_range(63);
            end
        end else if (roll < 80) begin
            a = $urandom_range(FLASH_BYTES - 1);
        end else if (roll < 90) begin
            a = FLASH_BYTES - 1 - $urandom_range(7);
        end else begin
            a = $urandom_range(24'hffffff, FLASH_BYTES);
        end
        return 24'(a);
    endfunction

    // Drive both channels; gaps are switched off over a stretch of words.
    always @(posedge aclk) begin
        logic calm;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            calm = (words_sent >= 250 && words_sent < 400);
            if (!s_valid || s_ready) begin
                if (words_sent < stim_q.size() && (calm || $urandom_range(99) >= 14)) begin
                    s_valid     <= 1'b1;
                    s_command   <= stim_q[words_sent].cmd;
                    s_mosi_byte <= stim_q[words_sent].mosi;
                    words_sent++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 14);
        end
    end

    // Check each MISO word against the oldest expectation, then run the
    // model on any input word taken at this edge.
    always @(posedge aclk) begin
        logic [7:0] miso_pred;
        logic [7:0] miso_exp;
        word_row_t  row;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (miso_expected_q.size() == 0) begin
                    $error("miso_byte: no word expected, got %02h", m_miso_byte);
                    fail_count++;
                end else begin
                    miso_exp = miso_expected_q.pop_front();
                    if (m_miso_byte !== miso_exp) begin
                        $error("miso_byte: expected %02h, got %02h", miso_exp, m_miso_byte);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                row = stim_q[words_taken];
                if (miso_for_word(s_command, s_mosi_byte, miso_pred)) begin
                    miso_expected_q.push_back(row.typed ? row.miso : miso_pred);
                end
                words_taken++;
            end
        end
    end

    initial begin
        int         kind;
        int         n;
        logic [7:0] op;

        // Model reset: erased array and the fixed discovery image.
        for (int i = 0; i < FLASH_BYTES; i++) flash_image[i] = 8'hff;
        for (int i = 0; i < 96; i++) sfdp_image[i] = 8'h00;
        put_sfdp_word(spinor_pkg::WI_SIGNATURE, spinor_pkg::SFDP_SIGNATURE);
        put_sfdp_word(spinor_pkg::WI_HEADER, spinor_pkg::SFDP_HEADER);
        put_sfdp_word(spinor_pkg::WI_PARAM_HDR, spinor_pkg::SFDP_PARAM_HDR);
        put_sfdp_word(spinor_pkg::WI_PARAM_PTR, spinor_pkg::SFDP_PARAM_PTR);
        put_sfdp_word(spinor_pkg::WI_DENSITY, 32'(FLASH_BYTES * 8 - 1));
        put_sfdp_word(spinor_pkg::WI_ERASE, spinor_pkg::SFDP_ERASE_4K);
        wel = 1'b0;
        cur_opcode = 8'h00;
        byte_pos = '0;
        data_addr = '0;

        foreach (DIRECTED_ROWS[i]) stim_q.push_back(DIRECTED_ROWS[i]);

        // Random transactions, each closed by a release.
        while (stim_q.size() < N_DIRECTED + RANDOM_WORDS) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                push_word(CMD_BYTE, spinor_pkg::OP_WREN);
                push_random_bytes($urandom_range(2));
            end else if (kind < 18) begin
                push_word(CMD_BYTE, spinor_pkg::OP_RDSR);
                push_random_bytes($urandom_range(4, 1));
            end else if (kind < 24) begin
                push_word(CMD_BYTE, spinor_pkg::OP_RES);
                push_random_bytes($urandom_range(6, 1));
            end else if (kind < 34) begin
                push_word(CMD_BYTE, spinor_pkg::OP_RDSFDP);
                if ($urandom_range(99) < 70) begin
                    push_address(24'($urandom_range(100)));
                end else begin
                    push_address(pick_flash_address());
                end
                push_random_bytes($urandom_range(9, 1));
            end else if (kind < 54) begin
                push_word(CMD_BYTE, spinor_pkg::OP_READ);
                push_address(pick_flash_address());
                n = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(6, 1);
                push_random_bytes(n);
            end else if (kind < 74) begin
                if ($urandom_range(99) < 70) push_write_enable();
                push_word(CMD_BYTE, spinor_pkg::OP_PP);
                push_address(pick_flash_address());
                push_random_bytes($urandom_range(8, 1));
            end else if (kind < 84) begin
                if ($urandom_range(99) < 75) push_write_enable();
                push_word(CMD_BYTE, spinor_pkg::OP_SE);
                push_address(pick_flash_address());
                push_random_bytes($urandom_range(1));
            end else if (kind < 90) begin
                do begin
                    op = 8'($urandom);
                end while (op inside {spinor_pkg::OP_WREN, spinor_pkg::OP_RDSR,
                                      spinor_pkg::OP_RES, spinor_pkg::OP_RDSFDP,
                                      spinor_pkg::OP_READ, spinor_pkg::OP_PP,
                                      spinor_pkg::OP_SE});
                push_word(CMD_BYTE, op);
                push_random_bytes($urandom_range(4));
            end else if (kind >= 94) begin
                // Broken transaction: a known opcode cut short.
                case ($urandom_range(6))
                    0:       op = spinor_pkg::OP_WREN;
                    1:       op = spinor_pkg::OP_RDSR;
                    2:       op = spinor_pkg::OP_RES;
                    3:       op = spinor_pkg::OP_RDSFDP;
                    4:       op = spinor_pkg::OP_READ;
                    5:       op = spinor_pkg::OP_PP;
                    default: op = spinor_pkg::OP_SE;
                endcase
                push_word(CMD_BYTE, op);
                push_random_bytes($urandom_range(3));
            end
            push_word(CMD_RELEASE, 8'($urandom));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_taken < stim_q.size() || miso_expected_q.size() != 0) begin
            @(posedge aclk);
        end
        // Room for a sector erase still running to show any stray word.
        repeat (SECTOR_BYTES + 100) @(posedge aclk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
